### hw/rtl/tim_pkg.sv
// ----------------------------------------------------------------------------
// tim_pkg: shared types and constants of the tick interval monitor
// Register indexes, register reset values and the counter full-scale value.
// ----------------------------------------------------------------------------
package tim_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned TICK_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_INTERVAL = 3'd0,
        REG_MIN_INTERVAL = 3'd1,
        REG_SETTLE_TICKS = 3'd2,
        REG_WINDOW_TICKS = 3'd3,
        REG_ERROR_LIMIT  = 3'd4
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] RST_MAX_INTERVAL = 16'hFFFF;
    localparam logic [CFG_W-1:0] RST_MIN_INTERVAL = 16'd0;
    localparam logic [CFG_W-1:0] RST_SETTLE_TICKS = 16'd10;
    localparam logic [CFG_W-1:0] RST_WINDOW_TICKS = 16'd100;
    localparam logic [CFG_W-1:0] RST_ERROR_LIMIT  = 16'd5;

    // wrap base of the interval computation, also the error count ceiling
    localparam logic [CNT_W-1:0] WRAP_BASE = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

endpackage

### hw/rtl/tick_interval_monitor_core.sv
// ----------------------------------------------------------------------------
// tick_interval_monitor_core: timer tick monitor with windowed fault counter
// Computes the interval between timer samples, counts out-of-range intervals
// per window, raises a sticky fault and keeps a 32-bit tick counter.
// ----------------------------------------------------------------------------
// The result is registered: it is valid in the cycle after the input is accepted.
// Throughput: one tick per cycle while the result output is not stalled; the state
//   update is a single pass of subtract, compare and count logic at the input handshake.
// Reset (i_rst_n low, synchronous): registers return to defaults, settle and
//   window counters load the default settle and window values, the error and
//   tick counters clear, and the result register empties.
module tick_interval_monitor_core
    import tim_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // tick input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SAMPLE_W-1:0]  i_timer_sample,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SAMPLE_W-1:0]  o_interval,
    output logic                 o_fault,
    output logic [TICK_W-1:0]    o_safe_time
);

    logic [CFG_W-1:0]    r_max_interval;
    logic [CFG_W-1:0]    r_min_interval;
    logic [CFG_W-1:0]    r_window_ticks;
    logic [CFG_W-1:0]    r_error_limit;

    logic [SAMPLE_W-1:0] r_last_sample;
    logic [CNT_W-1:0]    r_settle_cnt;
    logic [CNT_W-1:0]    r_window_cnt;
    logic [CNT_W-1:0]    r_err_cnt;
    logic [TICK_W-1:0]   r_tick_cnt;

    logic [CNT_W-1:0]    n_settle_cnt;
    logic [CNT_W-1:0]    n_window_cnt;
    logic [CNT_W-1:0]    n_err_cnt;
    logic [TICK_W-1:0]   n_tick_cnt;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_interval;
    logic                r_out_fault;
    logic [TICK_W-1:0]   r_out_safe_time;

    logic [SAMPLE_W-1:0] interval;
    logic                fault;
    logic [CNT_W-1:0]    err_a;
    logic                accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_interval <= RST_MAX_INTERVAL;
            r_min_interval <= RST_MIN_INTERVAL;
            r_window_ticks <= RST_WINDOW_TICKS;
            r_error_limit  <= RST_ERROR_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MAX_INTERVAL: r_max_interval <= i_cfg_wdata;
                REG_MIN_INTERVAL: r_min_interval <= i_cfg_wdata;
                // settle count loads only at reset, which restores the default value
                REG_SETTLE_TICKS: ;
                REG_WINDOW_TICKS: r_window_ticks <= i_cfg_wdata;
                REG_ERROR_LIMIT:  r_error_limit  <= i_cfg_wdata;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ---------------- per-tick update ----------------
    always_comb begin
        // a backward step wraps one count short of the modular difference
        if (i_timer_sample < r_last_sample) begin
            interval = WRAP_BASE - r_last_sample + i_timer_sample;
        end else begin
            interval = i_timer_sample - r_last_sample;
        end

        n_settle_cnt = r_settle_cnt;
        err_a        = r_err_cnt;
        n_err_cnt    = r_err_cnt;
        if (r_settle_cnt != '0) begin
            n_settle_cnt = r_settle_cnt - 1'b1;
        end else begin
            // both bounds can fail at once when max is below min
            if (interval > r_max_interval && r_err_cnt != CNT_MAX) begin
                err_a = r_err_cnt + 1'b1;
            end
            n_err_cnt = err_a;
            if (interval < r_min_interval && err_a != CNT_MAX) begin
                n_err_cnt = err_a + 1'b1;
            end
        end

        fault        = 1'b0;
        n_window_cnt = r_window_cnt;
        if (r_window_cnt != '0) begin
            n_window_cnt = r_window_cnt - 1'b1;
        end else if (n_err_cnt > r_error_limit) begin
            fault = 1'b1;  // hold window at zero: fault repeats every tick
        end else begin
            n_window_cnt = r_window_ticks;
            n_err_cnt    = '0;
        end

        n_tick_cnt = r_tick_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
            r_settle_cnt  <= RST_SETTLE_TICKS;
            r_window_cnt  <= RST_WINDOW_TICKS;
            r_err_cnt     <= '0;
            r_tick_cnt    <= '0;
        end else if (accept) begin
            r_last_sample <= i_timer_sample;
            r_settle_cnt  <= n_settle_cnt;
            r_window_cnt  <= n_window_cnt;
            r_err_cnt     <= n_err_cnt;
            r_tick_cnt    <= n_tick_cnt;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_interval  <= interval;
            r_out_fault     <= fault;
            r_out_safe_time <= n_tick_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_interval  = r_out_interval;
    assign o_fault     = r_out_fault;
    assign o_safe_time = r_out_safe_time;

    // ---------------- assertions ----------------
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_tick_cnt == $past(r_tick_cnt) + 1'b1 && o_safe_time == r_tick_cnt)
        else $error("tick counter or safe_time out of step");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    a_settle_no_errors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_settle_cnt != '0 && r_window_cnt != '0
        |=> r_err_cnt == $past(r_err_cnt))
        else $error("error counted during settling");

    a_err_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_window_cnt != '0 |=> r_err_cnt >= $past(r_err_cnt))
        else $error("error count fell inside a window");

endmodule
